// File: rtl/dbs_pkg.sv
package dbs_pkg;

	// Operation codes carried by an input item.
	localparam logic [1:0] OP_PUSH_FIRST  = 2'd0;
	localparam logic [1:0] OP_PUSH_SECOND = 2'd1;
	localparam logic [1:0] OP_FETCH       = 2'd2;

	// Decimal digit limits.
	localparam logic [3:0] DIGIT_MAX = 4'd9;
	localparam logic [4:0] RADIX     = 5'd10;

	// Input item.
	typedef struct packed {
		logic [1:0] opcode;
		logic [3:0] digit_in;
	} cmd_t;

	// Result item.
	typedef struct packed {
		logic [3:0] digit_out;
		logic       negative;
		logic       last;
		logic       overflow;
	} res_t;

endpackage

// File: rtl/decimal_bignum_subtractor_core.sv
// Decimal big-number subtractor. Digits of the first and second operand are pushed most
// significant first (opcodes 0 and 1) and each fetch (opcode 2) returns one digit of
// first minus second, most significant first, without leading zeros, with a negative
// flag and a last flag on the final digit; equal or empty operands give a single 0.
// Digits above nine are stored as nine, and digits pushed into a full store are dropped
// and raise overflow. The first fetch after pushes runs a compare pass and then a borrow
// pass over N digits, N being the length of the longer operand (at least one); the passes
// walk the two digit memories one digit per cycle through their single read ports. Each
// fetch then reads the difference store and loads the digit into the result register.
// After the last digit has been fetched all stores and flags are empty again.
module decimal_bignum_subtractor_core
	import dbs_pkg::*;
#(
	parameter int MAX_DIGITS = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_DIGITS);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_CMP  = 7'b0000010,
		ST_SUB  = 7'b0000100,
		ST_FIN  = 7'b0001000,
		ST_LOAD = 7'b0010000,
		ST_READ = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t state_q;

	// Digit stores.
	logic [3:0] first_mem [MAX_DIGITS];
	logic [3:0] second_mem [MAX_DIGITS];
	logic [3:0] diff_mem [MAX_DIGITS];

	logic [CW-1:0] cnt_a_q, cnt_b_q, len_q, n_q, pos_q;
	logic [AW-1:0] rp_q, start_q;
	logic          done_q, neg_q, ovf_q, decided_q, borrow_q;
	logic [3:0]    rd_a_q, rd_b_q, diff_rd_q;

	// Serial pass stage.
	logic          cmp_s1, sub_s1, ina_s1, inb_s1;
	logic [AW-1:0] waddr_s1;

	logic          res_valid_q;
	res_t          res_q;

	logic          cmd_fire, push_a, push_b, fetch, fin;
	logic [3:0]    dig_clamped;
	logic [CW-1:0] n_nxt, addr_a_full, addr_b_full, waddr_full;
	logic [3:0]    a_dig, b_dig, big, d;
	logic [4:0]    small5, diff5;
	logic          borrow_nxt;

	// Input handshake: one item at a time, fetch only when the result register can load.
	assign cmd_stall = (state_q != ST_IDLE) || (res_valid_q && res_stall);
	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign push_a    = cmd_fire && (cmd.opcode == OP_PUSH_FIRST);
	assign push_b    = cmd_fire && (cmd.opcode == OP_PUSH_SECOND);
	assign fetch     = cmd_fire && (cmd.opcode == OP_FETCH);
	assign dig_clamped = (cmd.digit_in > DIGIT_MAX) ? DIGIT_MAX : cmd.digit_in;

	// Working length is the longer operand, at least one digit.
	always_comb begin
		n_nxt = (cnt_a_q > cnt_b_q) ? cnt_a_q : cnt_b_q;
		if (n_nxt == '0) begin
			n_nxt = CW'(1);
		end
	end

	// Read addresses for digit weight pos_q, aligned at the least significant digit.
	assign addr_a_full = cnt_a_q - CW'(1) - pos_q;
	assign addr_b_full = cnt_b_q - CW'(1) - pos_q;
	assign waddr_full  = n_q - CW'(1) - pos_q;

	// Operand stores: written on push, read one digit per cycle during the passes.
	always_ff @(posedge clk) begin
		if (push_a && (cnt_a_q < MAX_C)) begin
			first_mem[cnt_a_q[AW-1:0]] <= dig_clamped;
		end
		rd_a_q <= first_mem[addr_a_full[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (push_b && (cnt_b_q < MAX_C)) begin
			second_mem[cnt_b_q[AW-1:0]] <= dig_clamped;
		end
		rd_b_q <= second_mem[addr_b_full[AW-1:0]];
	end

	// Difference store: written by the borrow pass, read at the read pointer.
	always_ff @(posedge clk) begin
		if (sub_s1) begin
			diff_mem[waddr_s1] <= d;
		end
		diff_rd_q <= diff_mem[rp_q];
	end

	// One borrow step on the digit pair in the pass stage.
	always_comb begin
		a_dig  = ina_s1 ? rd_a_q : '0;
		b_dig  = inb_s1 ? rd_b_q : '0;
		big    = neg_q ? b_dig : a_dig;
		small5 = {1'b0, (neg_q ? a_dig : b_dig)} + {4'd0, borrow_q};
		if ({1'b0, big} >= small5) begin
			diff5      = {1'b0, big} - small5;
			borrow_nxt = 1'b0;
		end else begin
			diff5      = {1'b0, big} + RADIX - small5;
			borrow_nxt = 1'b1;
		end
		d = diff5[3:0];
	end

	// The current fetch returns the final digit.
	assign fin = ({1'b0, CW'(rp_q)} + {{CW{1'b0}}, 1'b1}) >= {1'b0, len_q};

	// Pass stage registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_s1 <= 1'b0;
			sub_s1 <= 1'b0;
		end else begin
			cmp_s1 <= (state_q == ST_CMP);
			sub_s1 <= (state_q == ST_SUB);
		end
	end

	always_ff @(posedge clk) begin
		ina_s1   <= pos_q < cnt_a_q;
		inb_s1   <= pos_q < cnt_b_q;
		waddr_s1 <= waddr_full[AW-1:0];
	end

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_a_q   <= '0;
			cnt_b_q   <= '0;
			len_q     <= '0;
			n_q       <= '0;
			pos_q     <= '0;
			rp_q      <= '0;
			start_q   <= '0;
			done_q    <= 1'b0;
			neg_q     <= 1'b0;
			ovf_q     <= 1'b0;
			decided_q <= 1'b0;
			borrow_q  <= 1'b0;
		end else begin
			// Compare step, most significant position first.
			if (cmp_s1 && !decided_q && (a_dig != b_dig)) begin
				decided_q <= 1'b1;
				neg_q     <= b_dig > a_dig;
			end
			// Borrow step; the last nonzero digit seen is the leading one.
			if (sub_s1) begin
				borrow_q <= borrow_nxt;
				if (d != '0) begin
					start_q <= waddr_s1;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (push_a || push_b) begin
						done_q <= 1'b0;
						neg_q  <= 1'b0;
						len_q  <= '0;
						rp_q   <= '0;
						if (push_a) begin
							if (cnt_a_q < MAX_C) begin
								cnt_a_q <= cnt_a_q + CW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end else begin
							if (cnt_b_q < MAX_C) begin
								cnt_b_q <= cnt_b_q + CW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end
					end else if (fetch) begin
						if (done_q) begin
							state_q <= ST_READ;
						end else begin
							n_q       <= n_nxt;
							pos_q     <= n_nxt - CW'(1);
							start_q   <= AW'(n_nxt - CW'(1));
							neg_q     <= 1'b0;
							decided_q <= 1'b0;
							borrow_q  <= 1'b0;
							state_q   <= ST_CMP;
						end
					end
				end
				ST_CMP: begin
					if (pos_q == '0) begin
						state_q <= ST_SUB;
					end else begin
						pos_q <= pos_q - CW'(1);
					end
				end
				ST_SUB: begin
					if (pos_q == n_q - CW'(1)) begin
						state_q <= ST_FIN;
					end else begin
						pos_q <= pos_q + CW'(1);
					end
				end
				ST_FIN: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					rp_q    <= start_q;
					len_q   <= n_q;
					done_q  <= 1'b1;
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
					if (fin) begin
						cnt_a_q <= '0;
						cnt_b_q <= '0;
						len_q   <= '0;
						rp_q    <= '0;
						done_q  <= 1'b0;
						neg_q   <= 1'b0;
						ovf_q   <= 1'b0;
					end else begin
						rp_q <= rp_q + AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_OUT) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT) begin
			res_q.digit_out <= diff_rd_q;
			res_q.negative  <= neg_q;
			res_q.last      <= fin;
			res_q.overflow  <= ovf_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// A readout step always presents an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> res_valid)
		else $error("readout step did not present an item");

	// A computed result never points past its end.
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ({1'b0, CW'(rp_q)} < {1'b0, len_q}))
		else $error("read pointer beyond difference length");

	// Returned digits are decimal.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.digit_out <= DIGIT_MAX))
		else $error("result digit above nine");

	// Fetching the final digit empties the operand stores.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OUT) && fin) |=> ((cnt_a_q == '0) && (cnt_b_q == '0) && !done_q))
		else $error("stores not cleared after final digit");

endmodule

// File: tb/sv/decimal_bignum_subtractor_checker.sv
`timescale 1ns / 1ps

module decimal_bignum_subtractor_checker
	import dbs_pkg::*;
#(
	parameter int MAX_DIGITS = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  logic cmd_stall,
	input  cmd_t cmd,
	input  logic res_valid,
	input  logic res_stall,
	input  res_t res,
	output int   fail_count,
	output int   pending_count
);

	// Shadow copy of the operand stores and of the difference being read out.
	logic [3:0]  minuend_store    [MAX_DIGITS];
	logic [3:0]  subtrahend_store [MAX_DIGITS];
	logic [3:0]  diff_store       [MAX_DIGITS];
	int unsigned minuend_len;
	int unsigned subtrahend_len;
	int unsigned diff_len;
	int unsigned diff_ptr;
	bit          diff_ready;
	bit          diff_neg;
	bit          lost_digits;

	// Result digits predicted but not yet seen on the result channel.
	res_t        digit_queue [$];
	res_t        want_item;

	// Digit at weight 10^p of one operand, zero beyond its length.
	function automatic int unsigned weight_digit(input bit from_second, input int unsigned p);
		if (from_second) begin
			if (p >= subtrahend_len)
				return 0;
			return subtrahend_store[subtrahend_len - 1 - p];
		end
		if (p >= minuend_len)
			return 0;
		return minuend_store[minuend_len - 1 - p];
	endfunction

	// Compare magnitudes, then subtract the smaller from the larger digit by digit.
	task automatic subtract_operands();
		int unsigned n;
		int unsigned p;
		int unsigned a;
		int unsigned b;
		int unsigned top_digit;
		int unsigned low_digit;
		int unsigned borrow;
		bit          found;
		bit          neg;

		n = (minuend_len > subtrahend_len) ? minuend_len : subtrahend_len;
		found = 1'b0;
		neg = 1'b0;
		for (p = n; p > 0; p--) begin
			a = weight_digit(1'b0, p - 1);
			b = weight_digit(1'b1, p - 1);
			if (!found && a != b) begin
				found = 1'b1;
				neg = b > a;
			end
		end

		borrow = 0;
		for (p = 0; p < n; p++) begin
			a = weight_digit(1'b0, p);
			b = weight_digit(1'b1, p);
			top_digit = neg ? b : a;
			low_digit = (neg ? a : b) + borrow;
			if (top_digit >= low_digit) begin
				diff_store[n - 1 - p] = 4'(top_digit - low_digit);
				borrow = 0;
			end else begin
				diff_store[n - 1 - p] = 4'(top_digit + 10 - low_digit);
				borrow = 1;
			end
		end

		if (n == 0) begin
			diff_store[0] = 4'd0;
			n = 1;
		end

		// Skip leading zeros but always keep the final digit.
		diff_ptr = 0;
		while (diff_ptr + 1 < n && diff_store[diff_ptr] == 4'd0)
			diff_ptr++;
		diff_len = n;
		diff_ready = 1'b1;
		diff_neg = neg;
	endtask

	// Update the shadow state for one accepted input item.
	task automatic apply_item(input cmd_t c);
		logic [3:0] dg;
		res_t       r;
		bit         fin;

		dg = (c.digit_in > DIGIT_MAX) ? DIGIT_MAX : c.digit_in;
		case (c.opcode)
			OP_PUSH_FIRST, OP_PUSH_SECOND: begin
				// Any push throws away a result that is still being read out.
				diff_ready = 1'b0;
				diff_neg = 1'b0;
				diff_len = 0;
				diff_ptr = 0;
				if (c.opcode == OP_PUSH_FIRST) begin
					if (minuend_len < MAX_DIGITS) begin
						minuend_store[minuend_len] = dg;
						minuend_len++;
					end else begin
						lost_digits = 1'b1;
					end
				end else begin
					if (subtrahend_len < MAX_DIGITS) begin
						subtrahend_store[subtrahend_len] = dg;
						subtrahend_len++;
					end else begin
						lost_digits = 1'b1;
					end
				end
			end
			OP_FETCH: begin
				if (!diff_ready || diff_ptr >= diff_len)
					subtract_operands();
				fin = diff_ptr + 1 >= diff_len;
				r.digit_out = diff_store[diff_ptr];
				r.negative = diff_neg;
				r.last = fin;
				r.overflow = lost_digits;
				digit_queue.push_back(r);
				// The final digit empties both stores and clears every flag.
				if (fin) begin
					minuend_len = 0;
					subtrahend_len = 0;
					diff_len = 0;
					diff_ptr = 0;
					diff_ready = 1'b0;
					diff_neg = 1'b0;
					lost_digits = 1'b0;
				end else begin
					diff_ptr++;
				end
			end
			default: begin
			end
		endcase
	endtask

	// Watch both channels: check result items first, then predict from input items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minuend_len = 0;
			subtrahend_len = 0;
			diff_len = 0;
			diff_ptr = 0;
			diff_ready = 1'b0;
			diff_neg = 1'b0;
			lost_digits = 1'b0;
			digit_queue.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (digit_queue.size() == 0) begin
					$display("%0t: unexpected result item, expected none, got digit %0d negative %0b last %0b overflow %0b",
						$time, res.digit_out, res.negative, res.last, res.overflow);
					fail_count++;
				end else begin
					want_item = digit_queue.pop_front();
					if (res.digit_out !== want_item.digit_out ||
						res.negative !== want_item.negative ||
						res.last !== want_item.last ||
						res.overflow !== want_item.overflow) begin
						$display("%0t: result item mismatch, expected digit %0d negative %0b last %0b overflow %0b",
							$time, want_item.digit_out, want_item.negative, want_item.last,
							want_item.overflow);
						$display("%0t: got digit %0d negative %0b last %0b overflow %0b",
							$time, res.digit_out, res.negative, res.last, res.overflow);
						fail_count++;
					end
				end
			end
			if (cmd_valid && !cmd_stall)
				apply_item(cmd);
			pending_count = digit_queue.size();
		end
	end

endmodule

// File: tb/sv/decimal_bignum_subtractor_core_test.sv
`timescale 1ns / 1ps

module decimal_bignum_subtractor_core_test;
	import dbs_pkg::*;

	localparam int MAX_DIGITS = 128;
	localparam int STIM_ITEMS = 700;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 16;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	int fail_count;
	int pending_count;
	int cycle_count = 0;
	int stuck_cycles = 0;
	int sent = 0;
	logic quiet;

	// Operand digits of the sequence being sent.
	logic [3:0] a_seq [0:MAX_DIGITS + 3];
	logic [3:0] b_seq [0:MAX_DIGITS + 3];
	int ia;
	int ib;
	int len_a;
	int len_b;
	int fetches;
	int pick;
	int seq;
	bit forced;

	decimal_bignum_subtractor_core #(
		.MAX_DIGITS(MAX_DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	decimal_bignum_subtractor_checker #(
		.MAX_DIGITS(MAX_DIGITS)
	) scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	// 50 MHz clock.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// A window in the middle of the run where neither side idles.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end
	assign quiet = cycle_count >= 1200 && cycle_count < 2200;

	// Outside the quiet window the result side stalls with a probability of about 15 percent.
	always @(negedge clk) begin
		res_stall <= !quiet && ($urandom_range(0, 99) < 15);
	end

	// End the run if no item moves on either channel for too long.
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// Offer one input item, with random idle cycles ahead of it, and wait until it is taken.
	task automatic send_item(input logic [1:0] op, input logic [3:0] dg);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 15) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= {op, dg};
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		if (op != OP_UNUSED)
			sent++;
	endtask

	// Random digit; a leading digit is mostly nonzero, and a few digits are above nine.
	function automatic logic [3:0] pick_digit(input bit leading);
		if ($urandom_range(0, 19) == 0)
			return 4'($urandom_range(10, 15));
		if (leading && $urandom_range(0, 9) != 0)
			return 4'($urandom_range(1, 9));
		return 4'($urandom_range(0, 9));
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Both stores empty: the result is a single zero.
		send_item(OP_FETCH, 4'd0);

		// Equal operands give zero; an unused opcode between the pushes changes nothing.
		send_item(OP_PUSH_FIRST, 4'd7);
		send_item(OP_UNUSED, 4'd15);
		send_item(OP_PUSH_SECOND, 4'd7);
		send_item(OP_FETCH, 4'd3);

		// A leading zero in the first operand; 03 - 12 is negative.
		send_item(OP_PUSH_FIRST, 4'd0);
		send_item(OP_PUSH_FIRST, 4'd3);
		send_item(OP_PUSH_SECOND, 4'd1);
		send_item(OP_PUSH_SECOND, 4'd2);
		send_item(OP_FETCH, 4'd0);
		send_item(OP_FETCH, 4'd0);

		// Digits above nine are stored as nine: 99 - 9.
		send_item(OP_PUSH_FIRST, 4'd15);
		send_item(OP_PUSH_FIRST, 4'd10);
		send_item(OP_PUSH_SECOND, 4'd9);
		send_item(OP_FETCH, 4'd15);
		send_item(OP_FETCH, 4'd0);

		// A push during readout of 500 - 1 discards it; the next fetches give 500 - 10.
		send_item(OP_PUSH_FIRST, 4'd5);
		send_item(OP_PUSH_FIRST, 4'd0);
		send_item(OP_PUSH_FIRST, 4'd0);
		send_item(OP_PUSH_SECOND, 4'd1);
		send_item(OP_FETCH, 4'd0);
		send_item(OP_PUSH_SECOND, 4'd0);
		send_item(OP_FETCH, 4'd0);
		send_item(OP_FETCH, 4'd0);
		send_item(OP_FETCH, 4'd0);

		// Random sequences: mostly two operands and a readout, a few long enough to fill a
		// store, some cut short by the next pushes, and some noise.
		sent = 0;
		seq = 0;
		while (sent < STIM_ITEMS) begin
			pick = $urandom_range(0, 99);
			forced = seq == 2 || seq == 5;
			if (seq == 2) begin
				len_a = $urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 3);
				len_b = $urandom_range(1, 4);
			end else if (seq == 5) begin
				len_a = 2;
				len_b = MAX_DIGITS + 1;
			end else if (pick < 85) begin
				len_a = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
				len_b = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
			end else begin
				len_a = 0;
				len_b = 0;
			end

			for (ia = 0; ia < len_a; ia++)
				a_seq[ia] = pick_digit(ia == 0);
			for (ib = 0; ib < len_b; ib++)
				b_seq[ib] = pick_digit(ib == 0);

			// Now and then make the operands equal or one digit apart.
			if (!forced && pick < 85 && $urandom_range(0, 5) == 0) begin
				len_b = len_a;
				for (ib = 0; ib < len_b; ib++)
					b_seq[ib] = a_seq[ib];
				if (len_b > 0 && $urandom_range(0, 1) == 1)
					b_seq[$urandom_range(0, len_b - 1)] = pick_digit(1'b0);
			end

			// Enough fetches to read the whole difference, sometimes fewer.
			fetches = (len_a > len_b) ? len_a : len_b;
			if (fetches > MAX_DIGITS)
				fetches = MAX_DIGITS;
			if (fetches == 0)
				fetches = 1;
			if (seq == 5)
				fetches = 4;
			else if (!forced && $urandom_range(0, 6) == 0)
				fetches = $urandom_range(1, fetches);
			if (!forced && pick >= 85)
				fetches = 0;

			// Push the two operands interleaved at random.
			ia = 0;
			ib = 0;
			while (ia < len_a || ib < len_b) begin
				if (ib >= len_b || (ia < len_a && $urandom_range(0, 1) == 1)) begin
					send_item(OP_PUSH_FIRST, a_seq[ia]);
					ia++;
				end else begin
					send_item(OP_PUSH_SECOND, b_seq[ib]);
					ib++;
				end
				if ($urandom_range(0, 49) == 0)
					send_item(OP_UNUSED, 4'($urandom_range(0, 15)));
			end

			repeat (fetches)
				send_item(OP_FETCH, 4'($urandom_range(0, 15)));

			// Noise: any opcode with any digit.
			if (!forced && pick >= 85) begin
				repeat ($urandom_range(1, 6))
					send_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
			end
			seq++;
		end

		@(negedge clk);
		cmd_valid <= 1'b0;

		// Let every predicted result arrive, then allow a few more cycles for strays.
		while (pending_count != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
